FILE: src/trdp_pkg.sv
// ----------------------------------------------------------------------------
// trdp_pkg
// Shared types, flag bit positions and the field layout decode for the
// treadmill data record parser.
// ----------------------------------------------------------------------------
package trdp_pkg;

    localparam int unsigned FLAG_NO_SPEED   = 0;
    localparam int unsigned FLAG_AVG_SPEED  = 1;
    localparam int unsigned FLAG_DISTANCE   = 2;
    localparam int unsigned FLAG_INCLINE    = 3;
    localparam int unsigned FLAG_ELEVATION  = 4;
    localparam int unsigned FLAG_INST_PACE  = 5;
    localparam int unsigned FLAG_AVG_PACE   = 6;
    localparam int unsigned FLAG_ENERGY     = 7;
    localparam int unsigned FLAG_HEART      = 8;

    localparam int unsigned MARK_SPEED   = 0;
    localparam int unsigned MARK_INCLINE = 1;
    localparam int unsigned MARK_ENERGY  = 2;
    localparam int unsigned MARK_HEART   = 3;

    localparam logic [7:0] POS_MAX = 8'hFF;

    typedef logic [4:0] offset_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } rec_byte_t;

    typedef struct packed {
        offset_t spd;
        offset_t inc;
        offset_t en;
        offset_t hr;
    } layout_t;

    function automatic layout_t compute_layout(input logic [15:0] f);
        layout_t l;
        offset_t off;
        l   = '0;
        off = 5'd2;
        if (!f[FLAG_NO_SPEED])
        begin
            l.spd = off;
            off   = off + 5'd2;
        end
        if (f[FLAG_AVG_SPEED])
            off = off + 5'd2;
        if (f[FLAG_DISTANCE])
            off = off + 5'd3;
        if (f[FLAG_INCLINE])
        begin
            l.inc = off;
            off   = off + 5'd4;
        end
        if (f[FLAG_ELEVATION])
            off = off + 5'd4;
        if (f[FLAG_INST_PACE])
            off = off + 5'd1;
        if (f[FLAG_AVG_PACE])
            off = off + 5'd1;
        if (f[FLAG_ENERGY])
        begin
            l.en = off;
            off  = off + 5'd5;
        end
        if (f[FLAG_HEART])
            l.hr = off;
        return l;
    endfunction

endpackage

FILE: src/trdp_in_if.sv
// ----------------------------------------------------------------------------
// trdp_in_if
// Byte request channel into the parser: one record byte and its last mark.
// ----------------------------------------------------------------------------
interface trdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: src/trdp_out_if.sv
// ----------------------------------------------------------------------------
// trdp_out_if
// Result request channel out of the parser: one summary per record.
// ----------------------------------------------------------------------------
interface trdp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] speed_centi_kmh;
    logic [15:0] incline_raw;
    logic [15:0] energy_kcal;
    logic [7:0]  heart_bpm;
    logic        heart_present;
    logic        heart_missing;
    logic        truncated;
    logic [15:0] record_flags;

    modport source (
        output valid, output speed_centi_kmh, output incline_raw, output energy_kcal,
        output heart_bpm, output heart_present, output heart_missing, output truncated,
        output record_flags, input ready
    );
    modport sink (
        input valid, input speed_centi_kmh, input incline_raw, input energy_kcal,
        input heart_bpm, input heart_present, input heart_missing, input truncated,
        input record_flags, output ready
    );
endinterface

FILE: src/trdp_in_stage.sv
// ----------------------------------------------------------------------------
// trdp_in_stage
// Input register: holds one accepted byte request until the parser takes it.
// ----------------------------------------------------------------------------
module trdp_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    trdp_in_if.sink             rec_in,
    input  logic                take,
    output logic                held_valid,
    output trdp_pkg::rec_byte_t held_byte
);
    import trdp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    rec_byte_t byte_reg;
    logic      accept;

    assign rec_in.ready = !valid_reg || take;
    assign accept       = rec_in.valid && rec_in.ready;
    assign valid_next   = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg.data_byte <= rec_in.data_byte;
            byte_reg.last_byte <= rec_in.last_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
endmodule

FILE: src/trdp_core.sv
// ----------------------------------------------------------------------------
// trdp_core
// Record state, field capture by byte position, and the result register.
// ----------------------------------------------------------------------------
module trdp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                held_valid,
    input  trdp_pkg::rec_byte_t held_byte,
    output logic                take,
    trdp_out_if.source          res_out
);
    import trdp_pkg::*;

    logic [7:0]  pos_reg,     pos_next,     pos_upd;
    logic [15:0] flag_reg,    flag_next,    flag_upd;
    logic [15:0] speed_reg,   speed_next;
    logic [15:0] incline_reg, incline_next;
    logic [15:0] energy_reg,  energy_next;
    logic [7:0]  heart_reg,   heart_next,   heart_upd;
    logic [7:0]  low_reg,     low_next,     low_upd;
    logic [3:0]  marks_reg,   marks_next,   marks_upd;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] res_speed_reg, res_incline_reg, res_energy_reg, res_flags_reg;
    logic [7:0]  res_heart_reg;
    logic        res_present_reg, res_missing_reg, res_trunc_reg;

    layout_t     lay;
    logic [7:0]  b;
    logic        last;
    logic        out_free;
    logic        emit;
    logic        trunc;

    assign b        = held_byte.data_byte;
    assign last     = held_byte.last_byte;
    assign out_free = !out_valid_reg || res_out.ready;
    assign take     = held_valid && (!last || out_free);
    assign emit     = take && last;
    assign lay      = compute_layout(flag_reg);

    always_comb
    begin
        pos_upd      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 8'd1;
        flag_upd     = flag_reg;
        speed_next   = speed_reg;
        incline_next = incline_reg;
        energy_next  = energy_reg;
        heart_upd    = heart_reg;
        low_upd      = low_reg;
        marks_upd    = marks_reg;
        if (pos_reg == 8'd0)
            flag_upd = {8'h00, b};
        else if (pos_reg == 8'd1)
            flag_upd = {b, flag_reg[7:0]};
        else
        begin
            if (!flag_reg[FLAG_NO_SPEED])
            begin
                if (pos_reg == {3'b000, lay.spd})
                    low_upd = b;
                else if (pos_reg == {3'b000, lay.spd} + 8'd1)
                begin
                    speed_next            = {b, low_reg};
                    marks_upd[MARK_SPEED] = 1'b1;
                end
            end
            if (flag_reg[FLAG_INCLINE])
            begin
                if (pos_reg == {3'b000, lay.inc})
                    low_upd = b;
                else if (pos_reg == {3'b000, lay.inc} + 8'd1)
                begin
                    incline_next            = {b, low_reg};
                    marks_upd[MARK_INCLINE] = 1'b1;
                end
            end
            if (flag_reg[FLAG_ENERGY])
            begin
                if (pos_reg == {3'b000, lay.en})
                    low_upd = b;
                else if (pos_reg == {3'b000, lay.en} + 8'd1)
                begin
                    energy_next            = {b, low_reg};
                    marks_upd[MARK_ENERGY] = 1'b1;
                end
            end
            if (flag_reg[FLAG_HEART] && pos_reg == {3'b000, lay.hr})
            begin
                heart_upd             = b;
                marks_upd[MARK_HEART] = 1'b1;
            end
        end

        trunc = (!flag_upd[FLAG_NO_SPEED] && !marks_upd[MARK_SPEED])
             || (flag_upd[FLAG_INCLINE] && !marks_upd[MARK_INCLINE])
             || (flag_upd[FLAG_ENERGY] && !marks_upd[MARK_ENERGY]);

        // record state clears when the last byte of a record is taken
        pos_next   = last ? 8'd0  : pos_upd;
        flag_next  = last ? 16'd0 : flag_upd;
        heart_next = last ? 8'd0  : heart_upd;
        low_next   = last ? 8'd0  : low_upd;
        marks_next = last ? 4'd0  : marks_upd;

        out_valid_next = emit ? 1'b1 : (res_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            flag_reg      <= '0;
            speed_reg     <= '0;
            incline_reg   <= '0;
            energy_reg    <= '0;
            heart_reg     <= '0;
            low_reg       <= '0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pos_reg     <= pos_next;
                flag_reg    <= flag_next;
                speed_reg   <= speed_next;
                incline_reg <= incline_next;
                energy_reg  <= energy_next;
                heart_reg   <= heart_next;
                low_reg     <= low_next;
                marks_reg   <= marks_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_speed_reg   <= speed_next;
            res_incline_reg <= incline_next;
            res_energy_reg  <= energy_next;
            res_heart_reg   <= marks_upd[MARK_HEART] ? heart_upd : 8'd0;
            res_present_reg <= marks_upd[MARK_HEART];
            res_missing_reg <= flag_upd[FLAG_HEART] && !marks_upd[MARK_HEART];
            res_trunc_reg   <= trunc;
            res_flags_reg   <= flag_upd;
        end
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.speed_centi_kmh = res_speed_reg;
    assign res_out.incline_raw     = res_incline_reg;
    assign res_out.energy_kcal     = res_energy_reg;
    assign res_out.heart_bpm       = res_heart_reg;
    assign res_out.heart_present   = res_present_reg;
    assign res_out.heart_missing   = res_missing_reg;
    assign res_out.truncated       = res_trunc_reg;
    assign res_out.record_flags    = res_flags_reg;
endmodule

FILE: src/treadmill_data_record_parser_unit.sv
// ----------------------------------------------------------------------------
// treadmill_data_record_parser_unit
// Parses treadmill data records fed one byte per request and emits one
// summary request per record.
//
// rec_in carries data_byte and last_byte; a request completes when valid and
// ready are both high. res_out carries the summary of a record: held speed,
// inclination and energy, the heart byte with its present and missing flags,
// the truncated flag and the record's flag word.
// Throughput is one byte per cycle unless a last byte waits on a stalled
// res_out. A byte is captured in the input register and then decoded into the
// result register, so a summary is valid once its last byte has passed both.
// If res_out stalls, bytes that end no record keep flowing; a last byte waits
// in the input register, holding rec_in ready low, until the result register
// frees.
// Reset clears the record position, flag word, held values and both valid
// bits; the first summary after reset reports zero for fields never seen.
// ----------------------------------------------------------------------------
module treadmill_data_record_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    trdp_in_if.sink    rec_in,
    trdp_out_if.source res_out
);
    import trdp_pkg::*;

    logic      held_valid;
    rec_byte_t held_byte;
    logic      take;

    trdp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_in     (rec_in),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    trdp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .take       (take),
        .res_out    (res_out)
    );
endmodule
